### hdl/abc128_pkg.sv
package abc128_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int NUM_RW      = 32;
    localparam int RW_AW       = $clog2(NUM_RW);
    localparam int NUM_ROUNDS  = 16;

    localparam logic [31:0] KEY_BIAS = 32'h33cf_c738;
    localparam logic [31:0] KEY_MIX  = 32'h1986_0719;

    typedef logic [31:0] t_word;
    typedef logic [3:0][31:0] t_blk;
    typedef logic [NUM_RW-1:0][31:0] t_keys;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_ENC  = 2'd1,
        OP_DEC  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef struct packed {
        logic busy;
        logic done;
    } t_ks_stat;

    // per round: state word, chain words, whitening targets and key indexes
    localparam int PLAN_ST [NUM_ROUNDS] = '{3,3,3,3,3,3,1,1,1,1,0,0,0,0,0,0};
    localparam int PLAN_C0 [NUM_ROUNDS] = '{0,0,1,1,2,2,0,0,2,2,1,1,2,2,3,3};
    localparam int PLAN_C1 [NUM_ROUNDS] = '{1,2,0,2,0,1,2,3,0,3,2,3,1,3,1,2};
    localparam int PLAN_C2 [NUM_ROUNDS] = '{2,1,2,0,1,0,3,2,3,0,3,2,3,1,2,1};
    localparam int PLAN_T0 [NUM_ROUNDS] = '{3,3,3,3,3,1,1,1,1,0,0,0,0,0,0,0};
    localparam int PLAN_T1 [NUM_ROUNDS] = '{0,1,1,2,2,0,0,2,2,1,1,2,2,3,3,0};
    localparam int PLAN_T2 [NUM_ROUNDS] = '{2,0,2,0,1,2,3,0,3,2,3,1,3,1,2,0};
    localparam int PLAN_T3 [NUM_ROUNDS] = '{1,2,0,1,0,3,2,3,0,3,2,3,1,2,1,0};
    localparam int PLAN_W0 [NUM_ROUNDS] =
        '{17,18,19,20,21,22,23,24,25,26,27,28,29,30,31,0};
    localparam int PLAN_W1 [NUM_ROUNDS] =
        '{20,21,22,23,24,25,26,27,28,29,30,31,0,1,2,0};
    localparam int PLAN_W2 [NUM_ROUNDS] =
        '{22,23,24,25,26,27,28,29,30,31,0,1,2,3,4,0};
    localparam int PLAN_W3 [NUM_ROUNDS] =
        '{24,25,26,27,28,29,30,31,0,1,2,3,4,5,6,0};

    function automatic t_word rotl(input t_word x, input int c);
        return (x << c) | (x >> (32 - c));
    endfunction

    function automatic t_blk whiten(input t_keys kw);
        return {kw[16], kw[23], kw[21], kw[19]};
    endfunction

endpackage

### hdl/abc128_ram.sv
module abc128_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/abc128_ks.sv
module abc128_ks (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [63:0]                i_key_low,
    input  logic [63:0]                i_key_high,
    output logic [abc128_pkg::TBL_AW-1:0] o_tbl_raddr,
    input  abc128_pkg::t_word          i_tbl_rdata,
    output abc128_pkg::t_ks_stat       o_stat,
    output abc128_pkg::t_keys          o_kw
);
    import abc128_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_A, S_B, S_C, S_D, S_IDX, S_E, S_F, S_IV, S_S, S_V,
        S_G1, S_G2, S_G3, S_G4, S_G5, S_G6, S_G7, S_LOAD,
        S_SW0, S_SW1, S_SW2, S_SW3, S_OUT
    } t_state;

    t_state              r_state;
    logic                r_done;
    logic [5:0]          r_cnt;
    t_word               r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_hold;
    logic [TBL_AW-1:0]   r_idx, r_base;
    t_word               r_iv  [28];
    t_word               r_pre [NUM_RW];
    t_word               r_q   [4];
    t_keys               r_kw;

    t_word               w_f, w_g, w_prej;
    logic [RW_AW-1:0]    w_sel;
    logic [5:0]          w_cm1;
    logic                swp_we;
    logic [RW_AW-1:0]    swp_waddr, swp_raddr;
    t_word               swp_wdata, swp_rdata;

    assign w_f    = rotl(r_e, 2) ^ r_b;
    assign w_g    = rotl(w_f, 3) ^ r_c;
    assign w_prej = r_pre[r_cnt[RW_AW-1:0]];
    assign w_sel  = r_cnt[5] ? w_prej[12:8] : w_prej[4:0];
    assign w_cm1  = r_cnt - 6'd1;

    always_comb begin
        swp_we      = 1'b0;
        swp_waddr   = r_cnt[RW_AW-1:0];
        swp_wdata   = w_prej;
        swp_raddr   = r_cnt[RW_AW-1:0];
        o_tbl_raddr = r_base + r_cnt;
        case (r_state)
            S_IDX: begin
                o_tbl_raddr = {r_d[4:0], r_d[31]};
            end
            S_LOAD: begin
                swp_we = 1'b1;
            end
            S_SW0: begin
                swp_raddr = w_sel;
            end
            S_SW2: begin
                swp_we    = 1'b1;
                swp_waddr = w_sel;
                swp_wdata = swp_rdata;
            end
            S_SW3: begin
                swp_we    = 1'b1;
                swp_wdata = r_hold;
            end
            default: begin
            end
        endcase
    end

    abc128_ram #(.WIDTH(32), .DEPTH(NUM_RW)) u_swp (
        .i_clk   (i_clk),
        .i_we    (swp_we),
        .i_waddr (swp_waddr),
        .i_wdata (swp_wdata),
        .i_raddr (swp_raddr),
        .o_rdata (swp_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_start) begin
                        r_state <= S_A;
                    end
                end
                S_A: begin
                    r_a     <= i_key_low[31:0] - KEY_BIAS;
                    r_state <= S_B;
                end
                S_B: begin
                    r_b     <= rotl(r_a, 5) + i_key_low[63:32];
                    r_state <= S_C;
                end
                S_C: begin
                    r_c     <= rotl(r_b, 7) + i_key_high[31:0];
                    r_state <= S_D;
                end
                S_D: begin
                    r_d     <= rotl(r_c, 11) + i_key_high[63:32];
                    r_state <= S_IDX;
                end
                S_IDX: begin
                    r_idx   <= {r_d[4:0], r_d[31]};
                    r_state <= S_E;
                end
                S_E: begin
                    r_e     <= rotl((rotl(r_d, 2) + i_tbl_rdata) ^ KEY_MIX, 1) ^ r_a;
                    r_state <= S_F;
                end
                S_F: begin
                    r_f     <= w_f;
                    r_g     <= w_g;
                    r_d     <= r_d ^ rotl(w_g, 4);
                    r_base  <= r_e[TBL_AW-1:0] + r_idx;
                    r_cnt   <= '0;
                    r_state <= S_IV;
                end
                S_IV: begin
                    if (r_cnt != 6'd0) begin
                        r_iv[w_cm1[4:0]] <= i_tbl_rdata;
                    end
                    if (r_cnt == 6'd28) begin
                        r_cnt   <= '0;
                        r_state <= S_S;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_S: begin
                    r_q[0]  <= r_e + r_iv[0] + r_iv[1] + (r_iv[2] << 1);
                    r_q[1]  <= r_f + r_iv[0] + r_iv[1] + (r_iv[2] << 1);
                    r_q[2]  <= r_g + ((r_iv[0] + r_iv[1]) << 1);
                    r_q[3]  <= r_d + (r_iv[3] << 2);
                    r_state <= S_V;
                end
                S_V: begin
                    r_pre[0] <= rotl(r_q[0], 5);
                    r_pre[1] <= rotl(r_q[1], 9);
                    r_pre[2] <= rotl(r_q[2], 13);
                    r_pre[3] <= rotl(r_q[3], 17);
                    r_q[0]   <= r_q[3] + r_iv[0];
                    r_q[1]   <= r_q[0] + r_iv[1];
                    r_q[2]   <= r_q[1] + r_iv[2];
                    r_q[3]   <= r_q[2] + r_iv[3];
                    r_state  <= S_G1;
                end
                S_G1: begin
                    r_pre[4] <= rotl(r_q[0], 5);
                    r_pre[5] <= rotl(r_q[1], 9);
                    r_pre[6] <= rotl(r_q[2], 13);
                    r_pre[7] <= rotl(r_q[3], 17);
                    r_q[0]   <= r_q[0] + r_iv[4];
                    r_q[1]   <= r_q[1] + r_iv[5];
                    r_q[2]   <= r_q[3] + r_iv[6];
                    r_q[3]   <= r_q[2] + r_iv[7];
                    r_state  <= S_G2;
                end
                S_G2: begin
                    r_pre[8]  <= rotl(r_q[0], 5);
                    r_pre[9]  <= rotl(r_q[1], 9);
                    r_pre[10] <= rotl(r_q[2], 13);
                    r_pre[11] <= rotl(r_q[3], 17);
                    r_q[0]    <= r_q[0] + r_iv[8];
                    r_q[3]    <= r_q[3] + r_iv[9];
                    r_q[1]    <= r_q[1] + r_iv[10];
                    r_q[2]    <= r_q[2] + r_iv[11];
                    r_state   <= S_G3;
                end
                S_G3: begin
                    r_pre[12] <= rotl(r_q[0], 5);
                    r_pre[13] <= rotl(r_q[3], 9);
                    r_pre[14] <= rotl(r_q[1], 13);
                    r_pre[15] <= rotl(r_q[2], 17);
                    r_q[0]    <= r_q[0] + r_iv[12];
                    r_q[3]    <= r_q[3] + r_iv[13];
                    r_q[2]    <= r_q[2] + r_iv[14];
                    r_q[1]    <= r_q[1] + r_iv[15];
                    r_state   <= S_G4;
                end
                S_G4: begin
                    r_pre[16] <= rotl(r_q[0], 5);
                    r_pre[17] <= rotl(r_q[3], 9);
                    r_pre[18] <= rotl(r_q[2], 13);
                    r_pre[19] <= rotl(r_q[1], 17);
                    r_q[0]    <= r_q[0] + r_iv[16];
                    r_q[2]    <= r_q[2] + r_iv[17];
                    r_q[1]    <= r_q[1] + r_iv[18];
                    r_q[3]    <= r_q[3] + r_iv[19];
                    r_state   <= S_G5;
                end
                S_G5: begin
                    r_pre[20] <= rotl(r_q[0], 5);
                    r_pre[21] <= rotl(r_q[2], 9);
                    r_pre[22] <= rotl(r_q[1], 13);
                    r_pre[23] <= rotl(r_q[3], 17);
                    r_q[0]    <= r_q[0] + r_iv[20];
                    r_q[2]    <= r_q[2] + r_iv[21];
                    r_q[3]    <= r_q[3] + r_iv[22];
                    r_q[1]    <= r_q[1] + r_iv[23];
                    r_state   <= S_G6;
                end
                S_G6: begin
                    r_pre[24] <= rotl(r_q[0], 5);
                    r_pre[25] <= rotl(r_q[2], 9);
                    r_pre[26] <= rotl(r_q[3], 13);
                    r_pre[27] <= rotl(r_q[1], 17);
                    r_q[3]    <= r_q[3] + r_iv[24];
                    r_q[1]    <= r_q[1] + r_iv[25];
                    r_q[2]    <= r_q[2] + r_iv[26];
                    r_q[0]    <= r_q[0] + r_iv[27];
                    r_state   <= S_G7;
                end
                S_G7: begin
                    r_pre[28] <= rotl(r_q[3], 5);
                    r_pre[29] <= rotl(r_q[1], 9);
                    r_pre[30] <= rotl(r_q[2], 13);
                    r_pre[31] <= rotl(r_q[0], 17);
                    r_cnt     <= '0;
                    r_state   <= S_LOAD;
                end
                S_LOAD: begin
                    if (r_cnt == 6'd31) begin
                        r_cnt   <= '0;
                        r_state <= S_SW0;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_SW0: begin
                    r_state <= S_SW1;
                end
                S_SW1: begin
                    r_hold  <= swp_rdata;
                    r_state <= S_SW2;
                end
                S_SW2: begin
                    r_state <= S_SW3;
                end
                S_SW3: begin
                    if (r_cnt == 6'd63) begin
                        r_cnt   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_cnt   <= r_cnt + 6'd1;
                        r_state <= S_SW0;
                    end
                end
                S_OUT: begin
                    if (r_cnt != 6'd0) begin
                        r_kw[w_cm1[RW_AW-1:0]] <= swp_rdata;
                    end
                    if (r_cnt == 6'd32) begin
                        r_cnt   <= '0;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.done = r_done;
    assign o_kw        = r_kw;

endmodule

### hdl/abc128_round.sv
module abc128_round #(
    parameter int P = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic               i_dec,
    input  abc128_pkg::t_blk   i_x,
    input  abc128_pkg::t_keys  i_kw,
    output logic               o_valid,
    output logic               o_dec,
    output abc128_pkg::t_blk   o_x,
    output logic               o_busy
);
    import abc128_pkg::*;

    // encrypt runs round P here, decrypt runs round 15-P
    localparam int RE  = P;
    localparam int RD  = NUM_ROUNDS - 1 - P;
    localparam int EST = PLAN_ST[RE];
    localparam int EC0 = PLAN_C0[RE];
    localparam int EC1 = PLAN_C1[RE];
    localparam int EC2 = PLAN_C2[RE];
    localparam int DST = PLAN_ST[RD];
    localparam int DC0 = PLAN_C0[RD];
    localparam int DC1 = PLAN_C1[RD];
    localparam int DC2 = PLAN_C2[RD];
    localparam bit EWH = (RE < NUM_ROUNDS - 1);
    localparam bit DWH = (RD < NUM_ROUNDS - 1);

    logic  r_va, r_vb, r_vc, r_da, r_db, r_dc;
    t_blk  r_xa, r_xb, r_xc;
    t_blk  w_ea, w_da, w_eb, w_db, w_ec, w_dc;
    t_word w_ps, w_dt, w_et, w_ek, w_ekn, w_dk, w_dkn;

    assign w_ek  = i_kw[RE];
    assign w_ekn = i_kw[RE + 1];
    assign w_dk  = i_kw[RD];
    assign w_dkn = i_kw[RD + 1];

    always_comb begin
        w_ps       = i_x[EST] + w_ek;
        w_ea       = i_x;
        w_ea[EC0]  = i_x[EC0] + rotl(w_ps, 1);
        w_ea[EST]  = w_ps;

        w_da = i_x;
        if (DWH) begin
            w_da[PLAN_T0[RD]] = w_da[PLAN_T0[RD]] ^ i_kw[PLAN_W0[RD]];
            w_da[PLAN_T1[RD]] = w_da[PLAN_T1[RD]] ^ i_kw[PLAN_W1[RD]];
            w_da[PLAN_T2[RD]] = w_da[PLAN_T2[RD]] ^ i_kw[PLAN_W2[RD]];
            w_da[PLAN_T3[RD]] = w_da[PLAN_T3[RD]] ^ i_kw[PLAN_W3[RD]];
        end
        w_da[DC2] = w_da[DC2] ^ rotl(w_dk, 1);
        w_dt      = (rotl(w_da[DC2], 5) + w_dk) ^ w_dkn;
        w_da[DST] = w_da[DST] ^ w_dt;
        w_da[DC0] = w_da[DC0] ^ rotl(w_dt, 1);
        w_da[DC1] = w_da[DC1] ^ rotl(w_dt, 2);
    end

    always_comb begin
        w_eb      = r_xa;
        w_eb[EC1] = r_xa[EC1] + rotl(r_xa[EC0], 2);
        w_eb[EC2] = r_xa[EC2] + rotl(w_eb[EC1], 3);

        w_db      = r_xa;
        w_db[DC2] = r_xa[DC2] - rotl(r_xa[DC1], 3);
        w_db[DC1] = r_xa[DC1] - rotl(r_xa[DC0], 2);
    end

    always_comb begin
        w_et      = (rotl(r_xb[EC2], 5) + w_ek) ^ w_ekn;
        w_ec      = r_xb;
        w_ec[EST] = r_xb[EST] ^ w_et;
        w_ec[EC0] = r_xb[EC0] ^ rotl(w_et, 1);
        w_ec[EC1] = r_xb[EC1] ^ rotl(w_et, 2);
        w_ec[EC2] = r_xb[EC2] ^ rotl(w_ek, 1);
        if (EWH) begin
            w_ec[PLAN_T0[RE]] = w_ec[PLAN_T0[RE]] ^ i_kw[PLAN_W0[RE]];
            w_ec[PLAN_T1[RE]] = w_ec[PLAN_T1[RE]] ^ i_kw[PLAN_W1[RE]];
            w_ec[PLAN_T2[RE]] = w_ec[PLAN_T2[RE]] ^ i_kw[PLAN_W2[RE]];
            w_ec[PLAN_T3[RE]] = w_ec[PLAN_T3[RE]] ^ i_kw[PLAN_W3[RE]];
        end

        w_dc      = r_xb;
        w_dc[DC0] = r_xb[DC0] - rotl(r_xb[DST], 1);
        w_dc[DST] = r_xb[DST] - w_dk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_da <= i_dec;
            r_db <= r_da;
            r_dc <= r_db;
            r_xa <= i_dec ? w_da : w_ea;
            r_xb <= r_da ? w_db : w_eb;
            r_xc <= r_db ? w_dc : w_ec;
        end
    end

    assign o_valid = r_vc;
    assign o_dec   = r_dc;
    assign o_x     = r_xc;
    assign o_busy  = r_va | r_vb | r_vc;

endmodule

### hdl/arx_block_cipher_128_top.sv
// Path: input register, 48 round stages (3 per round), output register.
// Throughput: one block per cycle while the receiver takes results and
// no key schedule runs. A table load or key write forces a key schedule
// before the next block: the pipeline drains, then the sequencer runs.
// Reset (synchronous, active low) clears valids and keys; table undefined.
module arx_block_cipher_128_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [5:0]  i_table_slot,
    input  logic [31:0] i_table_value,
    input  logic [63:0] i_block_in_low,
    input  logic [63:0] i_block_in_high,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_block_out_low,
    output logic [63:0] o_block_out_high,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import abc128_pkg::*;

    logic              r_dirty;
    logic [63:0]       r_key_lo, r_key_hi;
    logic              r_in_v, r_in_dec;
    t_blk              r_in_x;
    logic              r_out_v;
    t_blk              r_out_x;

    logic              cfg_wr, is_blk, load_acc, blk_acc, ks_start;
    logic              en, in_en, pipe_empty;
    logic [TBL_AW-1:0] tbl_raddr;
    t_word             tbl_rdata;
    t_ks_stat          ks_stat;
    t_keys             kw;
    t_blk              in_blk;

    logic              v_v [NUM_ROUNDS+1];
    logic              v_d [NUM_ROUNDS+1];
    t_blk              v_x [NUM_ROUNDS+1];
    logic [NUM_ROUNDS-1:0] busy;

    assign pready = 1'b1;
    assign prdata = paddr[3] ? r_key_hi : r_key_lo;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo <= '0;
            r_key_hi <= '0;
        end else if (cfg_wr) begin
            if (paddr[3]) begin
                r_key_hi <= pwdata;
            end else begin
                r_key_lo <= pwdata;
            end
        end
    end

    assign is_blk     = (i_operation == OP_ENC) || (i_operation == OP_DEC);
    assign en         = !r_out_v || i_ready;
    assign in_en      = en || !r_in_v;
    assign pipe_empty = !r_in_v && (busy == '0);
    assign o_ready    = !ks_stat.busy && (!is_blk || (!r_dirty && in_en));
    assign load_acc   = i_valid && o_ready && (i_operation == OP_LOAD);
    assign blk_acc    = i_valid && o_ready && is_blk;
    assign ks_start   = r_dirty && !ks_stat.busy && !ks_stat.done
                        && i_valid && is_blk && pipe_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty <= 1'b1;
        end else begin
            r_dirty <= (r_dirty && !ks_stat.done) || cfg_wr || load_acc;
        end
    end

    abc128_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_tbl (
        .i_clk   (i_clk),
        .i_we    (load_acc),
        .i_waddr (i_table_slot),
        .i_wdata (i_table_value),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    abc128_ks u_ks (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (ks_start),
        .i_key_low   (r_key_lo),
        .i_key_high  (r_key_hi),
        .o_tbl_raddr (tbl_raddr),
        .i_tbl_rdata (tbl_rdata),
        .o_stat      (ks_stat),
        .o_kw        (kw)
    );

    assign in_blk = {i_block_in_high, i_block_in_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (in_en) begin
            r_in_v <= blk_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_en) begin
            r_in_dec <= (i_operation == OP_DEC);
            r_in_x   <= (i_operation == OP_DEC) ? in_blk : (in_blk ^ whiten(kw));
        end
    end

    assign v_v[0] = r_in_v;
    assign v_d[0] = r_in_dec;
    assign v_x[0] = r_in_x;

    for (genvar p = 0; p < NUM_ROUNDS; p++) begin : g_rnd
        abc128_round #(.P(p)) u_rnd (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v_v[p]),
            .i_dec   (v_d[p]),
            .i_x     (v_x[p]),
            .i_kw    (kw),
            .o_valid (v_v[p+1]),
            .o_dec   (v_d[p+1]),
            .o_x     (v_x[p+1]),
            .o_busy  (busy[p])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= v_v[NUM_ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_x <= v_d[NUM_ROUNDS] ? (v_x[NUM_ROUNDS] ^ whiten(kw)) : v_x[NUM_ROUNDS];
        end
    end

    assign o_valid          = r_out_v;
    assign o_block_out_low  = {r_out_x[1], r_out_x[0]};
    assign o_block_out_high = {r_out_x[3], r_out_x[2]};

endmodule

### hdl/abc128_chk.sv
module abc128_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [1:0]  i_operation,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_block_out_low,
    input logic [63:0] o_block_out_high,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [63:0] pwdata,
    input logic [63:0] prdata,
    input logic        pready
);
    import abc128_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_block_out_low)
                                && $stable(o_block_out_high))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

    a_no_block_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !(i_valid && o_ready
                             && (i_operation == OP_ENC || i_operation == OP_DEC)))
        else $error("block taken before key schedule");

    a_key_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(psel && penable && pwrite && pready) && $past(i_rst_n)
        && psel && !pwrite && (paddr[3] == $past(paddr[3]))
        |-> prdata == $past(pwdata))
        else $error("key register readback mismatch");

endmodule

bind arx_block_cipher_128_top abc128_chk u_chk (.*);

### bench/tb_top.sv
module tb_top;
    import abc128_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 500;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
    } t_block_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_operation;
    logic [5:0]  i_table_slot;
    logic [31:0] i_table_value;
    logic [63:0] i_block_in_low;
    logic [63:0] i_block_in_high;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_block_out_low;
    logic [63:0] o_block_out_high;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    arx_block_cipher_128_top dut (.*);

    // st, c0, c1, c2, k, wt0..wt3, w0..w3
    int rplan [0:15][0:12] = '{
        '{3,0,1,2, 0, 3,0,2,1, 17,20,22,24},
        '{3,0,2,1, 1, 3,1,0,2, 18,21,23,25},
        '{3,1,0,2, 2, 3,1,2,0, 19,22,24,26},
        '{3,1,2,0, 3, 3,2,0,1, 20,23,25,27},
        '{3,2,0,1, 4, 3,2,1,0, 21,24,26,28},
        '{3,2,1,0, 5, 1,0,2,3, 22,25,27,29},
        '{1,0,2,3, 6, 1,0,3,2, 23,26,28,30},
        '{1,0,3,2, 7, 1,2,0,3, 24,27,29,31},
        '{1,2,0,3, 8, 1,2,3,0, 25,28,30,0},
        '{1,2,3,0, 9, 0,1,2,3, 26,29,31,1},
        '{0,1,2,3,10, 0,1,3,2, 27,30,0,2},
        '{0,1,3,2,11, 0,2,1,3, 28,31,1,3},
        '{0,2,1,3,12, 0,2,3,1, 29,0,2,4},
        '{0,2,3,1,13, 0,3,1,2, 30,1,3,5},
        '{0,3,1,2,14, 0,3,2,1, 31,2,4,6},
        '{0,3,2,1,15, 0,0,0,0, 0,0,0,0}
    };

    logic [63:0] key_lo, key_hi;
    logic [31:0] const_tbl [0:63];
    logic [31:0] subkey [0:31];
    t_block_word expected_blocks [$];
    int mismatches;
    int cycles;
    bit rx_hold;
    int rx_mode;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [31:0] rol(input logic [31:0] x, input int c);
        c = c & 31;
        return (c == 0) ? x : ((x << c) | (x >> (32 - c)));
    endfunction

    function automatic void derive_subkeys();
        logic [31:0] k0, k1, k2, k3, a, b, c, d, e, f, g, idx;
        logic [31:0] s0, s1, s2, s3, v0, v1, v2, v3, pa, pb, pc, pd, t;
        logic [31:0] iv [0:27];
        logic [31:0] rw [0:31];
        logic [4:0] sel [0:63];
        int j, s;
        k0 = key_lo[31:0]; k1 = key_lo[63:32];
        k2 = key_hi[31:0]; k3 = key_hi[63:32];
        a = k0 - KEY_BIAS;
        b = rol(a, 5) + k1;
        c = rol(b, 7) + k2;
        d = rol(c, 11) + k3;
        idx = rol(d, 1) & 32'h3f;
        e = (rol(d, 2) + const_tbl[idx]) ^ KEY_MIX;
        e = rol(e, 1) ^ a;
        f = rol(e, 2) ^ b;
        g = rol(f, 3) ^ c;
        idx = (e + idx) & 32'h3f;
        d = d ^ rol(g, 4);
        for (int i = 0; i < 28; i++) iv[i] = const_tbl[(idx + i) & 32'h3f];
        s0 = e + iv[0] + iv[1] + 2 * iv[2];
        s1 = f + iv[0] + iv[1] + 2 * iv[2];
        s2 = g + 2 * iv[0] + 2 * iv[1];
        s3 = d + 4 * iv[3];
        rw[0] = rol(s0, 5); rw[1] = rol(s1, 9); rw[2] = rol(s2, 13); rw[3] = rol(s3, 17);
        v0 = s3 + iv[0]; v1 = s0 + iv[1]; v2 = s1 + iv[2]; v3 = s2 + iv[3];
        rw[4] = rol(v0, 5); rw[5] = rol(v1, 9); rw[6] = rol(v2, 13); rw[7] = rol(v3, 17);
        pa = v0 + iv[4]; pb = v1 + iv[5]; pc = v3 + iv[6]; pd = v2 + iv[7];
        rw[8] = rol(pa, 5); rw[9] = rol(pb, 9); rw[10] = rol(pc, 13); rw[11] = rol(pd, 17);
        pa += iv[8]; pd += iv[9]; pb += iv[10]; pc += iv[11];
        rw[12] = rol(pa, 5); rw[13] = rol(pd, 9); rw[14] = rol(pb, 13); rw[15] = rol(pc, 17);
        pa += iv[12]; pd += iv[13]; pc += iv[14]; pb += iv[15];
        rw[16] = rol(pa, 5); rw[17] = rol(pd, 9); rw[18] = rol(pc, 13); rw[19] = rol(pb, 17);
        pa += iv[16]; pc += iv[17]; pb += iv[18]; pd += iv[19];
        rw[20] = rol(pa, 5); rw[21] = rol(pc, 9); rw[22] = rol(pb, 13); rw[23] = rol(pd, 17);
        pa += iv[20]; pc += iv[21]; pd += iv[22]; pb += iv[23];
        rw[24] = rol(pa, 5); rw[25] = rol(pc, 9); rw[26] = rol(pd, 13); rw[27] = rol(pb, 17);
        pd += iv[24]; pb += iv[25]; pc += iv[26];
        rw[28] = rol(pd, 5); rw[29] = rol(pb, 9); rw[30] = rol(pc, 13);
        rw[31] = rol(pa + iv[27], 17);
        for (int i = 0; i < 32; i++) begin
            sel[i] = rw[i][4:0];
            sel[32 + i] = rw[i][12:8];
        end
        for (int i = 0; i < 64; i++) begin
            j = i & 31;
            s = sel[i];
            t = rw[s];
            rw[s] = rw[j];
            rw[j] = t;
        end
        for (int i = 0; i < 32; i++) subkey[i] = rw[i];
    endfunction

    function automatic t_block_word encipher(input logic [63:0] lo, input logic [63:0] hi,
                                             input bit dec);
        logic [31:0] x [0:3];
        logic [31:0] ps, t;
        int st, c0, c1, c2, k, r;
        t_block_word res;
        x[0] = lo[31:0]; x[1] = lo[63:32]; x[2] = hi[31:0]; x[3] = hi[63:32];
        if (!dec) begin
            x[3] ^= subkey[16]; x[0] ^= subkey[19]; x[1] ^= subkey[21]; x[2] ^= subkey[23];
        end
        for (int n = 0; n < 16; n++) begin
            r = dec ? 15 - n : n;
            st = rplan[r][0]; c0 = rplan[r][1]; c1 = rplan[r][2]; c2 = rplan[r][3];
            k = rplan[r][4];
            if (!dec) begin
                ps = x[st] + subkey[k];
                x[c0] += rol(ps, 1);
                x[c1] += rol(x[c0], 2);
                x[c2] += rol(x[c1], 3);
                t = (rol(x[c2], 5) + subkey[k]) ^ subkey[k + 1];
                x[st] = ps ^ t;
                x[c0] ^= rol(t, 1);
                x[c1] ^= rol(t, 2);
                x[c2] ^= rol(subkey[k], 1);
            end
            if (r < 15) begin
                for (int w = 0; w < 4; w++) x[rplan[r][5 + w]] ^= subkey[rplan[r][9 + w]];
            end
            if (dec) begin
                x[c2] ^= rol(subkey[k], 1);
                t = (rol(x[c2], 5) + subkey[k]) ^ subkey[k + 1];
                x[st] ^= t;
                x[c0] ^= rol(t, 1);
                x[c1] ^= rol(t, 2);
                x[c2] -= rol(x[c1], 3);
                x[c1] -= rol(x[c0], 2);
                x[c0] -= rol(x[st], 1);
                x[st] -= subkey[k];
            end
        end
        if (dec) begin
            x[3] ^= subkey[16]; x[0] ^= subkey[19]; x[1] ^= subkey[21]; x[2] ^= subkey[23];
        end
        res.lo = {x[1], x[0]};
        res.hi = {x[3], x[2]};
        return res;
    endfunction

    // receiver stall pattern, plus a long hold-off when requested
    always @(negedge i_clk) begin
        if (cycles % 97 == 0) rx_mode <= $urandom_range(0, 3);
        if (rx_hold) i_ready <= 1'b0;
        else case (rx_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            2: i_ready <= ($urandom_range(0, 7) != 0);
            default: i_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_block_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_blocks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word lo=%h hi=%h", o_block_out_low, o_block_out_high);
            end else begin
                want = expected_blocks.pop_front();
                if (want.lo !== o_block_out_low || want.hi !== o_block_out_high) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("block mismatch: exp lo=%h hi=%h got lo=%h hi=%h",
                                 want.lo, want.hi, o_block_out_low, o_block_out_high);
                end
            end
        end
    end

    task automatic send_word(input t_op op, input logic [5:0] slot, input logic [31:0] val,
                             input logic [63:0] lo, input logic [63:0] hi);
        @(negedge i_clk);
        i_valid = 1'b1;
        i_operation = op;
        i_table_slot = slot;
        i_table_value = val;
        i_block_in_low = lo;
        i_block_in_high = hi;
        do @(posedge i_clk); while (!o_ready);
        case (op)
            OP_LOAD: const_tbl[slot] = val;
            OP_ENC, OP_DEC: begin
                derive_subkeys();
                expected_blocks.push_back(encipher(lo, hi, op == OP_DEC));
            end
            default: ;
        endcase
    endtask

    task automatic idle_gap(input int n);
        @(negedge i_clk);
        i_valid = 1'b0;
        i_operation = 2'($urandom);
        i_block_in_low = {$urandom, $urandom};
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        idle_gap(0);
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input bit wr, input int idx, input logic [63:0] data);
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = wr; paddr = 4'(idx * 8); pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (!wr && prdata !== data) begin
            mismatches++;
            if (mismatches <= 10) $display("reg %0d read exp %h got %h", idx, data, prdata);
        end
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0;
    endtask

    task automatic set_key(input logic [63:0] lo, input logic [63:0] hi);
        apb_xfer(1'b1, 0, lo);
        apb_xfer(1'b1, 1, hi);
        apb_xfer(1'b0, 0, lo);
        apb_xfer(1'b0, 1, hi);
        key_lo = lo;
        key_hi = hi;
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic test_table_fill();
        for (int i = 0; i < 64; i++)
            send_word(OP_LOAD, 6'(i), (i == 0) ? 32'h0 : (i == 63) ? 32'hffff_ffff : $urandom,
                      '0, '0);
        idle_gap(0);
    endtask

    task automatic test_directed();
        send_word(OP_NONE, 6'h3f, 32'hffff_ffff, '1, '1);
        send_word(OP_ENC, '0, '0, '0, '0);
        send_word(OP_DEC, '0, '0, '0, '0);
        send_word(OP_ENC, '0, '0, '1, '1);
        send_word(OP_DEC, '0, '0, '1, '1);
        drain();
        set_key('1, '1);
        send_word(OP_ENC, '0, '0, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        send_word(OP_DEC, '0, '0, '1, '0);
        send_word(OP_LOAD, 6'd63, 32'h0, '0, '0);
        send_word(OP_ENC, '0, '0, '0, '1);
        send_word(OP_LOAD, 6'd0, 32'hffff_ffff, '0, '0);
        send_word(OP_DEC, '0, '0, '1, '1);
        drain();
    endtask

    task automatic test_random(input int n_items);
        int r, burst;
        t_op op;
        burst = 0;
        for (int i = 0; i < n_items; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
            end
            burst--;
            r = $urandom_range(0, 99);
            op = (r < 3) ? OP_LOAD : (r < 6) ? OP_NONE : (r < 53) ? OP_ENC : OP_DEC;
            send_word(op, 6'($urandom), $urandom, rand64(), rand64());
        end
        drain();
    endtask

    task automatic test_backpressure();
        fork
            begin
                rx_hold = 1'b1;
                repeat (1000) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            for (int i = 0; i < 150; i++)
                send_word(($urandom_range(0, 1) != 0) ? OP_ENC : OP_DEC, '0, '0,
                          rand64(), rand64());
        join
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = OP_NONE;
        i_table_slot = '0;
        i_table_value = '0;
        i_block_in_low = '0;
        i_block_in_high = '0;
        i_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        key_lo = '0;
        key_hi = '0;
        mismatches = 0;
        cycles = 0;
        rx_hold = 1'b0;
        rx_mode = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_table_fill();
        test_directed();
        set_key('0, '0);
        test_random(250);
        set_key({$urandom, $urandom}, {$urandom, $urandom});
        test_backpressure();
        test_random(300);
        set_key(64'h8000_0000_0000_0001, 64'h7fff_ffff_ffff_fffe);
        test_random(300);
        set_key({$urandom, $urandom}, {$urandom, $urandom});
        test_random(250);

        if (mismatches == 0 && expected_blocks.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
